@@ sv/rdpu_pkg.sv @@
// Shared types and constants of the row delta prediction undo block.
package rdpu_pkg;

	// Sample depth codes.
	localparam logic [1:0] DEPTH_8  = 2'd0;
	localparam logic [1:0] DEPTH_16 = 2'd1;
	localparam logic [1:0] DEPTH_32 = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SAMPLE_DEPTH     = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT     = 2'd1;
	localparam logic [1:0] REG_ROWS_PER_CHANNEL = 2'd2;

	// Largest row in samples; also the depth of each plane store memory.
	localparam int MAX_COLUMNS = 4096;

	localparam int COL_W   = 13;
	localparam int ROW_W   = 16;
	localparam int POS_W   = 14;
	localparam int LEN_W   = 15;

	// Steps of the serial position divider, one per bit of the byte position.
	localparam logic [3:0] DIV_LAST = 4'(POS_W - 1);

	// Job queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic [1:0]        depth;
		logic [COL_W-1:0]  cols;
		logic [ROW_W-1:0]  rows;
	} cfg_t;

	// One emitting input: up to four restored bytes, most significant first.
	typedef struct packed {
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
		logic            row_end;
		logic            channel_end;
	} job_t;

endpackage

@@ sv/row_delta_prediction_undo_core.sv @@
// Top level of the row delta prediction undo block with its register port.
//
// Predicted bytes enter on push/full: a byte is taken at a clock edge with
// push high and full low. Restored bytes leave on empty/pop: the oldest beat
// is on out_byte and its flags while empty is low, and pop takes it.
// Each byte in 8-bit mode gives one beat; every second byte in 16-bit mode
// gives two; every plane 3 byte in 32-bit mode gives four, the plane 0 to 2
// bytes of that column coming from the plane store.
// The first beat of an input passes the job register, the queue and the
// result register. Input and output each move one beat per cycle while full
// is low and pop is high; the back emits one byte per cycle from a four-job
// queue, so the average output matches the input. When the receiver
// stalls, the result register holds, the queue fills and full rises;
// nothing is dropped. A register write starts a rebuild of plane and column
// from the byte position in a serial divider; full stays high until it ends.
// Reset clears sums, positions, counters and all handshakes; the plane store
// is not cleared and needs no clearing pass.
module row_delta_prediction_undo_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	input  logic [7:0]  in_byte,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        row_end,
	output logic        channel_end
);
	import rdpu_pkg::*;

	logic [1:0]       sample_depth_q;
	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] rows_per_channel_q;
	logic             cfg_wr;
	cfg_t             cfg;
	logic             q_full;
	logic             q_push;
	job_t             q_din;
	logic             q_empty;
	logic             q_pop;
	job_t             q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_depth_q     <= DEPTH_8;
			column_count_q     <= COL_W'(1);
			rows_per_channel_q <= ROW_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SAMPLE_DEPTH:     sample_depth_q     <= pwdata[1:0];
				REG_COLUMN_COUNT:     column_count_q     <= pwdata[COL_W-1:0];
				REG_ROWS_PER_CHANNEL: rows_per_channel_q <= pwdata[ROW_W-1:0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SAMPLE_DEPTH:     prdata = {30'b0, sample_depth_q};
			REG_COLUMN_COUNT:     prdata = {19'b0, column_count_q};
			REG_ROWS_PER_CHANNEL: prdata = {16'b0, rows_per_channel_q};
			default:              prdata = '0;
		endcase
	end

	assign cfg.depth = sample_depth_q;
	assign cfg.cols  = column_count_q;
	assign cfg.rows  = rows_per_channel_q;

	rdpu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr),
		.push    (push),
		.in_byte (in_byte),
		.full    (full),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_din   (q_din)
	);

	rdpu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	rdpu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.row_end     (row_end),
		.channel_end (channel_end)
	);

endmodule

@@ sv/rdpu_front.sv @@
// Front part: accepts predicted bytes, tracks row position and sums, holds the plane store.
module rdpu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  rdpu_pkg::cfg_t cfg,
	input  logic           cfg_wr,
	input  logic           push,
	input  logic [7:0]     in_byte,
	output logic           full,
	input  logic           q_full,
	output logic           q_push,
	output rdpu_pkg::job_t q_din
);
	import rdpu_pkg::*;

	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	logic [COL_W-1:0] eff_cols;
	logic [ROW_W-1:0] eff_rows;
	logic [1:0]       mode;
	logic [LEN_W-1:0] row_len;

	logic [15:0]      sum_q, sum_d;
	logic [7:0]       held_q, held_d;
	logic [POS_W-1:0] bp_q, bp_d;
	logic [ROW_W-1:0] rc_q, rc_d;
	logic [1:0]       plane_q, plane_d;
	logic [COL_W-1:0] col_q, col_d;

	logic             busy_q;
	logic [3:0]       div_cnt_q;
	logic [COL_W-1:0] div_rem_q;
	logic [POS_W-1:0] div_dvd_q;
	logic [POS_W-1:0] div_quo_q;
	logic [POS_W-1:0] div_sh;
	logic             div_ge;
	logic [COL_W-1:0] div_rem_n;
	logic [POS_W-1:0] div_quo_n;
	logic [1:0]       div_plane;

	logic             accept;
	logic             emit;
	logic             use_mem;
	logic [2:0]       we;
	logic [7:0]       sum8;
	logic [15:0]      sum16;
	logic             row_done;
	logic             ch_done;
	logic [COL_W-1:0] col_inc;
	logic [AW-1:0]    addr;
	job_t             job_d;

	logic             job_valid_s1;
	job_t             job_s1;
	logic             mem_s1;
	logic [7:0]       rd0_s1, rd1_s1, rd2_s1;

	logic [7:0] mem0 [MAX_COLUMNS];
	logic [7:0] mem1 [MAX_COLUMNS];
	logic [7:0] mem2 [MAX_COLUMNS];

	always_comb begin
		if (cfg.cols == '0) begin
			eff_cols = COL_W'(1);
		end else if ({4'b0, cfg.cols} > 17'(MAX_COLUMNS)) begin
			eff_cols = COL_W'(MAX_COLUMNS);
		end else begin
			eff_cols = cfg.cols;
		end
		eff_rows = (cfg.rows == '0) ? ROW_W'(1) : cfg.rows;
		mode = (cfg.depth == DEPTH_16 || cfg.depth == DEPTH_32) ? cfg.depth : DEPTH_8;
		case (mode)
			DEPTH_16: row_len = {1'b0, eff_cols, 1'b0};
			DEPTH_32: row_len = {eff_cols, 2'b00};
			default:  row_len = {2'b00, eff_cols};
		endcase
	end

	assign accept   = push && !full;
	assign sum8     = sum_q[7:0] + in_byte;
	assign sum16    = sum_q + {held_q, in_byte};
	assign row_done = ({1'b0, bp_q} + LEN_W'(1)) >= row_len;
	assign ch_done  = ({1'b0, rc_q} + 17'd1) >= {1'b0, eff_rows};
	assign col_inc  = col_q + COL_W'(1);
	assign addr     = AW'(col_q);

	always_comb begin
		sum_d   = sum_q;
		held_d  = held_q;
		bp_d    = bp_q;
		rc_d    = rc_q;
		plane_d = plane_q;
		col_d   = col_q;
		emit    = 1'b0;
		use_mem = 1'b0;
		we      = 3'b000;
		job_d   = '0;
		case (mode)
			DEPTH_16: begin
				if (!bp_q[0]) begin
					held_d = in_byte;
				end else begin
					sum_d = sum16;
					emit = 1'b1;
					job_d.bytes[0] = sum16[15:8];
					job_d.bytes[1] = sum16[7:0];
					job_d.last_idx = 2'd1;
				end
			end
			DEPTH_32: begin
				sum_d = {8'h00, sum8};
				if (plane_q != 2'd3) begin
					we[plane_q] = 1'b1;
				end else begin
					emit = 1'b1;
					use_mem = 1'b1;
					job_d.bytes[3] = sum8;
					job_d.last_idx = 2'd3;
				end
			end
			default: begin
				sum_d = {8'h00, sum8};
				emit = 1'b1;
				job_d.bytes[0] = sum8;
				job_d.last_idx = 2'd0;
			end
		endcase
		if (emit && row_done) begin
			bp_d    = '0;
			sum_d   = '0;
			plane_d = 2'd0;
			col_d   = '0;
			rc_d    = ch_done ? '0 : rc_q + ROW_W'(1);
			job_d.row_end     = 1'b1;
			job_d.channel_end = ch_done;
		end else begin
			bp_d = bp_q + POS_W'(1);
			if (col_inc == eff_cols) begin
				col_d   = '0;
				plane_d = (plane_q == 2'd3) ? 2'd3 : plane_q + 2'd1;
			end else begin
				col_d = col_inc;
			end
		end
	end

	// Restoring divider: rebuilds plane and column from the byte position
	// after any register write, one quotient bit per cycle.
	always_comb begin
		div_sh    = {div_rem_q, div_dvd_q[POS_W-1]};
		div_ge    = div_sh >= {1'b0, eff_cols};
		div_rem_n = div_ge ? COL_W'(div_sh - {1'b0, eff_cols}) : div_sh[COL_W-1:0];
		div_quo_n = {div_quo_q[POS_W-2:0], div_ge};
		div_plane = (div_quo_n > POS_W'(3)) ? 2'd3 : div_quo_n[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			held_q    <= '0;
			bp_q      <= '0;
			rc_q      <= '0;
			plane_q   <= '0;
			col_q     <= '0;
			busy_q    <= 1'b0;
			div_cnt_q <= '0;
			div_rem_q <= '0;
			div_dvd_q <= '0;
			div_quo_q <= '0;
		end else begin
			if (cfg_wr) begin
				busy_q    <= 1'b1;
				div_cnt_q <= '0;
				div_rem_q <= '0;
				div_dvd_q <= bp_q;
				div_quo_q <= '0;
			end else if (busy_q) begin
				div_cnt_q <= div_cnt_q + 4'd1;
				div_rem_q <= div_rem_n;
				div_dvd_q <= {div_dvd_q[POS_W-2:0], 1'b0};
				div_quo_q <= div_quo_n;
				if (div_cnt_q == DIV_LAST) begin
					busy_q  <= 1'b0;
					col_q   <= div_rem_n;
					plane_q <= div_plane;
				end
			end
			if (accept) begin
				sum_q   <= sum_d;
				held_q  <= held_d;
				bp_q    <= bp_d;
				rc_q    <= rc_d;
				plane_q <= plane_d;
				col_q   <= col_d;
			end
		end
	end

	// Plane store, one byte memory per stored plane.
	always_ff @(posedge clk) begin
		if (accept && we[0]) begin
			mem0[addr] <= sum8;
		end
		if (accept && we[1]) begin
			mem1[addr] <= sum8;
		end
		if (accept && we[2]) begin
			mem2[addr] <= sum8;
		end
		if (accept && use_mem) begin
			rd0_s1 <= mem0[addr];
			rd1_s1 <= mem1[addr];
			rd2_s1 <= mem2[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (accept) begin
			job_valid_s1 <= emit;
		end else if (q_push) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
			mem_s1 <= use_mem;
		end
	end

	assign q_push = job_valid_s1 && !q_full;
	assign full   = busy_q || (job_valid_s1 && q_full);

	always_comb begin
		q_din = job_s1;
		if (mem_s1) begin
			q_din.bytes[0] = rd0_s1;
			q_din.bytes[1] = rd1_s1;
			q_din.bytes[2] = rd2_s1;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !accept) else $error("byte accepted during position rebuild");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (col_q < eff_cols)) else $error("column outside row");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_s1 && q_full) |=> (job_valid_s1 && $stable(job_s1)))
		else $error("stalled job lost");

endmodule

@@ sv/rdpu_queue.sv @@
// Short job queue that decouples the front from the back.
module rdpu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rdpu_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output rdpu_pkg::job_t dout,
	output logic           empty
);
	import rdpu_pkg::*;

	job_t               slots [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slots[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/rdpu_back.sv @@
// Back part: splits each job into restored bytes and drives the result register.
module rdpu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  rdpu_pkg::job_t q_head,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           last_of_run,
	output logic           row_end,
	output logic           channel_end
);
	import rdpu_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       row_end_q;
	logic       channel_end_q;
	logic       load;
	logic       take;
	logic       is_last;

	assign load    = !out_valid_q || pop;
	assign take    = load && !q_empty;
	assign is_last = idx_q == q_head.last_idx;
	assign q_pop   = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (take) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q    <= q_head.bytes[idx_q];
			last_q        <= is_last;
			row_end_q     <= is_last && q_head.row_end;
			channel_end_q <= is_last && q_head.channel_end;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign row_end     = row_end_q;
	assign channel_end = channel_end_q;

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q <= q_head.last_idx)) else $error("byte index past job");

endmodule

@@ verif/row_delta_prediction_undo_checker.sv @@
// Row delta prediction undo checker: predicts every restored beat and checks register reads.
module row_delta_prediction_undo_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        push,
	input  logic [7:0]  in_byte,
	input  logic        full,
	input  logic        pop,
	input  logic        empty,
	input  logic [7:0]  out_byte,
	input  logic        last_of_run,
	input  logic        row_end,
	input  logic        channel_end,
	output int unsigned pending,
	output int unsigned fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import rdpu_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       row_done;
		logic       chan_done;
	} beat_t;

	beat_t restored_q [$];

	logic [1:0]  depth_r;
	logic [12:0] cols_r;
	logic [15:0] rows_r;

	logic [15:0] run_sum;
	logic [7:0]  held_hi;
	int unsigned byte_pos;
	logic [15:0] row_cnt;
	logic [23:0] plane_store [MAX_COLUMNS];

	int unsigned mismatches = 0;

	function automatic int unsigned active_cols();
		if (cols_r == 0) return 1;
		if (cols_r > MAX_COLUMNS) return MAX_COLUMNS;
		return cols_r;
	endfunction

	function automatic void queue_beat(input beat_t b);
		restored_q = {restored_q, b};
	endfunction

	// Only steps that emit get here. The row test uses the current length, so a row
	// that was shortened by a register write ends on the next emitting byte.
	function automatic void step_position(input int unsigned row_len, output logic row_done,
			output logic chan_done);
		int unsigned nrows;
		nrows = (rows_r == 0) ? 1 : rows_r;
		row_done = 1'b0;
		chan_done = 1'b0;
		if (byte_pos + 1 >= row_len) begin
			byte_pos = 0;
			run_sum = '0;
			row_done = 1'b1;
			if (row_cnt + 1 >= nrows) begin
				row_cnt = '0;
				chan_done = 1'b1;
			end else begin
				row_cnt = row_cnt + 1'b1;
			end
		end else begin
			byte_pos++;
		end
	endfunction

	task automatic predict_restore(input logic [7:0] b);
		int unsigned ncols;
		int unsigned plane;
		int unsigned col;
		logic [7:0]  sum8;
		logic [15:0] word;
		logic [23:0] stored;
		logic        rd;
		logic        cd;
		ncols = active_cols();
		case (depth_r)
			DEPTH_16: begin
				if (byte_pos % 2 == 0) begin
					held_hi = b;
					byte_pos++;
				end else begin
					run_sum = run_sum + {held_hi, b};
					word = run_sum;
					step_position(2 * ncols, rd, cd);
					queue_beat(beat_t'{word[15:8], 1'b0, 1'b0, 1'b0});
					queue_beat(beat_t'{word[7:0], 1'b1, rd, cd});
				end
			end
			DEPTH_32: begin
				plane = byte_pos / ncols;
				col = byte_pos % ncols;
				run_sum = (run_sum + b) & 16'h00FF;
				sum8 = run_sum[7:0];
				if (plane < 3) begin
					if (plane == 0) plane_store[col][23:16] = sum8;
					else if (plane == 1) plane_store[col][15:8] = sum8;
					else plane_store[col][7:0] = sum8;
					byte_pos++;
				end else begin
					// Any plane index past three, left over after a column change, acts as plane three.
					stored = plane_store[col];
					step_position(4 * ncols, rd, cd);
					queue_beat(beat_t'{stored[23:16], 1'b0, 1'b0, 1'b0});
					queue_beat(beat_t'{stored[15:8], 1'b0, 1'b0, 1'b0});
					queue_beat(beat_t'{stored[7:0], 1'b0, 1'b0, 1'b0});
					queue_beat(beat_t'{sum8, 1'b1, rd, cd});
				end
			end
			default: begin
				run_sum = (run_sum + b) & 16'h00FF;
				sum8 = run_sum[7:0];
				step_position(ncols, rd, cd);
				queue_beat(beat_t'{sum8, 1'b1, rd, cd});
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		beat_t       want;
		logic        bad;
		logic [31:0] reg_value;
		if (!arst_n) begin
			depth_r = DEPTH_8;
			cols_r = 13'd1;
			rows_r = 16'd1;
			run_sum = '0;
			held_hi = '0;
			byte_pos = 0;
			row_cnt = '0;
			restored_q.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_SAMPLE_DEPTH:     depth_r = pwdata[1:0];
						REG_COLUMN_COUNT:     cols_r = pwdata[12:0];
						REG_ROWS_PER_CHANNEL: rows_r = pwdata[15:0];
						default: ;
					endcase
				end else if (paddr[3:2] != 2'd3) begin
					case (paddr[3:2])
						REG_SAMPLE_DEPTH:     reg_value = 32'(depth_r);
						REG_COLUMN_COUNT:     reg_value = 32'(cols_r);
						default:              reg_value = 32'(rows_r);
					endcase
					if (prdata !== reg_value) begin
						$display("%0t: register %0d read expected %h, got %h",
							$time, paddr[3:2], reg_value, prdata);
						mismatches++;
					end
				end
			end
			if (pop && !empty) begin
				if (restored_q.size() == 0) begin
					$display("%0t: beat %h with nothing expected, expected none, got %h",
						$time, out_byte, out_byte);
					mismatches++;
				end else begin
					want = restored_q.pop_front();
					bad = 1'b0;
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %h, got %h", $time, want.data, out_byte);
						bad = 1'b1;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %b, got %b",
							$time, want.last, last_of_run);
						bad = 1'b1;
					end
					if (row_end !== want.row_done) begin
						$display("%0t: row_end expected %b, got %b", $time, want.row_done, row_end);
						bad = 1'b1;
					end
					if (channel_end !== want.chan_done) begin
						$display("%0t: channel_end expected %b, got %b",
							$time, want.chan_done, channel_end);
						bad = 1'b1;
					end
					if (bad) mismatches++;
				end
			end
			if (push && !full) predict_restore(in_byte);
		end
		pending <= restored_q.size();
		fail_count <= mismatches;
	end

endmodule

@@ verif/tb_row_delta_prediction_undo_core.sv @@
// Testbench top for row_delta_prediction_undo_core: drives bytes and registers, gives the verdict.
module tb_row_delta_prediction_undo_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rdpu_pkg::*;

	// The unused fourth depth code decodes as 8-bit samples.
	localparam logic [1:0] DEPTH_RESERVED = 2'd3;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 80;
	localparam int RANDOM_ITEMS = 125;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push;
	logic [7:0]  in_byte;
	logic        full;
	logic        pop;
	logic        empty;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        row_end;
	logic        channel_end;

	int unsigned pending;
	int unsigned fail_count;

	int unsigned items_sent = 0;
	int unsigned corner_idx = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;
	logic        quiet = 1'b0;

	logic [7:0] corner_bytes [6] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE};

	row_delta_prediction_undo_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.in_byte     (in_byte),
		.full        (full),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.row_end     (row_end),
		.channel_end (channel_end)
	);

	row_delta_prediction_undo_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.in_byte     (in_byte),
		.full        (full),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.row_end     (row_end),
		.channel_end (channel_end),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 7) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full !== 1'b0);
		items_sent++;
	endtask

	task automatic send_corners(input int unsigned n);
		repeat (n) begin
			send_byte(corner_bytes[corner_idx % 6]);
			corner_idx++;
		end
	endtask

	task automatic send_random(input int unsigned n);
		repeat (n) send_byte(8'($urandom));
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
	endtask

	// A plane byte gives no beat, so the block may still be busy once the last beat is out.
	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] depth, input logic [12:0] cols,
			input logic [15:0] rows);
		wait_idle();
		apb_access(1'b1, REG_SAMPLE_DEPTH, 32'(depth));
		apb_access(1'b1, REG_COLUMN_COUNT, 32'(cols));
		apb_access(1'b1, REG_ROWS_PER_CHANNEL, 32'(rows));
		apb_access(1'b0, REG_SAMPLE_DEPTH, '0);
		apb_access(1'b0, REG_COLUMN_COUNT, '0);
		apb_access(1'b0, REG_ROWS_PER_CHANNEL, '0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: random pops, plus long hold-offs on request so that the block backs up.
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else begin
				pop <= quiet || ($urandom_range(99) >= 7);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_row_delta_prediction_undo_core: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned directed_items;
		int unsigned phase;
		int unsigned carry;
		int unsigned ncols;
		int unsigned len;
		logic [1:0]  depth;
		logic [12:0] cols;
		logic [15:0] rows;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		in_byte = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		configure(DEPTH_8, 13'd2, 16'd2);
		send_corners(4);
		configure(DEPTH_16, 13'd2, 16'd1);
		send_corners(4);
		configure(DEPTH_32, 13'd2, 16'd3);
		send_corners(8);
		// Reserved depth, zero columns and zero rows all fall back to the smallest setting.
		configure(DEPTH_RESERVED, 13'd0, 16'd0);
		send_corners(2);
		// Shrinking the column count mid-row ends the row on the next byte.
		configure(DEPTH_8, 13'd4096, 16'hFFFF);
		send_corners(3);
		configure(DEPTH_8, 13'd2, 16'hFFFF);
		send_corners(1);
		// Fewer columns in the middle of a 32-bit row put the position past plane three.
		configure(DEPTH_32, 13'd2, 16'd1);
		send_corners(6);
		configure(DEPTH_32, 13'd1, 16'd1);
		send_corners(1);
		directed_items = items_sent;

		// A phase may stop inside a row only when the next one is in 8-bit mode, so that a
		// 32-bit row always starts at its first byte and never reads an unwritten column.
		phase = 0;
		carry = 0;
		while (items_sent - directed_items < RANDOM_ITEMS) begin
			phase++;
			if (carry != 0) depth = ($urandom_range(1) == 0) ? DEPTH_8 : DEPTH_RESERVED;
			else depth = 2'($urandom_range(3));
			if (carry != 0) begin
				cols = 13'($urandom_range(6));
			end else begin
				case ($urandom_range(9))
					0: cols = 13'd0;
					1: cols = 13'h1FFF;
					2: cols = 13'($urandom_range(7, 4096));
					default: cols = 13'($urandom_range(1, 6));
				endcase
			end
			case ($urandom_range(7))
				0: rows = 16'd0;
				1: rows = 16'hFFFF;
				default: rows = 16'($urandom_range(1, 4));
			endcase
			if (phase == 1) begin
				depth = DEPTH_8;
				cols = 13'd5;
				rows = 16'd3;
			end
			configure(depth, cols, rows);
			quiet = (phase >= 3 && phase <= 5);
			if (phase == 1 || phase == 6) holds_asked++;

			ncols = (cols == 0) ? 1 : (cols > 4096) ? 4096 : cols;
			len = ncols * ((depth == DEPTH_16) ? 2 : (depth == DEPTH_32) ? 4 : 1);
			if (carry != 0) begin
				send_random((carry + 1 >= len) ? 1 : len - carry);
				carry = 0;
			end
			if (len > 24) begin
				carry = $urandom_range(1, 8);
				send_random(carry);
			end else begin
				send_random(len * ((phase == 1) ? 5 : $urandom_range(1, 3)));
				if (len > 1 && $urandom_range(3) == 0) begin
					carry = $urandom_range(1, len - 1);
					send_random(carry);
				end
			end
		end
		quiet = 1'b0;

		wait_idle();
		if (fail_count == 0) $display("tb_row_delta_prediction_undo_core: PASS");
		else $display("tb_row_delta_prediction_undo_core: FAIL");
		$finish;
	end

endmodule
